>>> hw/rtl/weighted_sum_compositor_assert.svh
`ifndef WEIGHTED_SUM_COMPOSITOR_ASSERT_SVH
`define WEIGHTED_SUM_COMPOSITOR_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define WSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define WSC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/wsc_pkg.sv
`default_nettype none

package wsc_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int POINTS_DEF   = 1024;

  localparam int CMD_W   = 1;
  localparam int POINT_W = 11;
  localparam int CHAN_W  = 2;
  localparam int FEAT_W  = 16;
  localparam int ALPHA_W = 16;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = FEAT_W + ALPHA_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ENTRY = 1'b1;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> hw/rtl/wsc_in_if.sv
`default_nettype none

interface wsc_in_if import wsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [POINT_W-1:0] point_index;
  logic [CHAN_W-1:0]         channel;
  logic signed [FEAT_W-1:0]  feature_value;
  logic [ALPHA_W-1:0]        alpha;
  logic                      last_entry;

  modport source (output valid, command, point_index, channel, feature_value, alpha,
                  last_entry, input ready);
  modport sink (input valid, command, point_index, channel, feature_value, alpha,
                last_entry, output ready);
  modport mon (input valid, ready, command, point_index, channel, feature_value, alpha,
               last_entry);
endinterface

`default_nettype wire

>>> hw/rtl/wsc_out_if.sv
`default_nettype none

interface wsc_out_if import wsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CHAN_W-1:0]        out_channel;
  logic signed [ACC_W-1:0]  value;
  logic                     last_channel;

  modport source (output valid, out_channel, value, last_channel, input ready);
  modport sink (input valid, out_channel, value, last_channel, output ready);
  modport mon (input valid, ready, out_channel, value, last_channel);
endinterface

`default_nettype wire

>>> hw/rtl/weighted_sum_compositor.sv
// A pixel's last entry passes s1, s2 and s3 before its results fill the output buffer.
// One item per cycle if not stalled; a pixel's CHANNELS results go one per ready cycle.
// The input stalls only while a finished pixel waits for the previous burst to drain.
// Reset is synchronous, active low: it clears the pipeline, accumulators and output burst.
// The feature table is not cleared and must be loaded before it is read.
`default_nettype none

module weighted_sum_compositor import wsc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int POINTS   = POINTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  wsc_in_if.sink   in_ch,
  wsc_out_if.source out_ch
);

  localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CNT_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic advance;
  logic in_accept;

  logic                      s1_valid_r;
  logic [CMD_W-1:0]          s1_cmd_r;
  logic signed [POINT_W-1:0] s1_point_r;
  logic [CHAN_W-1:0]         s1_chan_r;
  feat_t                     s1_feat_r;
  logic [ALPHA_W-1:0]        s1_alpha_r;
  logic                      s1_last_r;

  logic [31:0]       s1_pt_u;
  logic              s1_pt_ok;
  logic              s1_load_ok;
  logic [ADDR_W-1:0] s1_addr;

  logic               s2_entry_r;
  logic               s2_hit_r;
  logic               s2_last_r;
  logic [ALPHA_W-1:0] s2_alpha_r;
  logic [FEAT_W-1:0]  rd_data [CHANNELS];

  logic  s3_valid_r;
  logic  s3_last_r;
  prod_t s3_prod_r [CHANNELS];
  prod_t prod_nxt [CHANNELS];

  acc_t acc_r [CHANNELS];
  acc_t acc_sum [CHANNELS];

  acc_t             obuf_r [CHANNELS];
  logic             out_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_last;
  logic             buf_free;

  assign out_last  = (32'(cnt_r) == 32'(CHANNELS - 1));
  assign buf_free  = !out_valid_r || (out_ch.ready && out_last);
  assign advance   = !(s3_valid_r && s3_last_r && !buf_free);
  assign in_accept = in_ch.valid && advance;

  assign in_ch.ready         = advance;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = obuf_r[0];
  assign out_ch.out_channel  = CHAN_W'(cnt_r);
  assign out_ch.last_channel = out_last;

  assign s1_pt_u    = 32'(s1_point_r[POINT_W-2:0]);
  assign s1_pt_ok   = !s1_point_r[POINT_W-1] && (s1_pt_u < 32'(POINTS));
  assign s1_load_ok = s1_valid_r && (s1_cmd_r == CMD_LOAD) && s1_pt_ok &&
                      (32'(s1_chan_r) < 32'(CHANNELS));
  assign s1_addr    = s1_pt_u[ADDR_W-1:0];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    wsc_ram #(
      .WIDTH(FEAT_W),
      .DEPTH(POINTS)
    ) u_ram (
      .clk  (clk),
      .we   (advance && s1_load_ok && (32'(s1_chan_r) == c)),
      .waddr(s1_addr),
      .wdata(s1_feat_r),
      .re   (advance),
      .raddr(s1_addr),
      .rdata(rd_data[c])
    );

    always_comb begin
      logic signed [ACC_W:0] sum;
      prod_nxt[c] = prod_t'($signed(rd_data[c])) * prod_t'($signed({1'b0, s2_alpha_r}));
      if (!s2_hit_r) begin
        prod_nxt[c] = '0;
      end
      sum = {acc_r[c][ACC_W-1], acc_r[c]} +
            {{(ACC_W+1-PROD_W){s3_prod_r[c][PROD_W-1]}}, s3_prod_r[c]};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_sum[c] = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_sum[c] = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd_r   <= in_ch.command;
      s1_point_r <= in_ch.point_index;
      s1_chan_r  <= in_ch.channel;
      s1_feat_r  <= in_ch.feature_value;
      s1_alpha_r <= in_ch.alpha;
      s1_last_r  <= in_ch.last_entry;
      s2_hit_r   <= s1_valid_r && (s1_cmd_r == CMD_ENTRY) && s1_pt_ok;
      s2_last_r  <= s1_last_r;
      s2_alpha_r <= s1_alpha_r;
      s3_last_r  <= s2_last_r;
      s3_prod_r  <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_entry_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        acc_r[c] <= '0;
      end
    end else begin
      if (advance) begin
        s1_valid_r <= in_accept;
        s2_entry_r <= s1_valid_r && (s1_cmd_r == CMD_ENTRY);
        s3_valid_r <= s2_entry_r;
      end
      if (out_valid_r && out_ch.ready) begin
        if (out_last) begin
          out_valid_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (advance && s3_valid_r) begin
        if (s3_last_r) begin
          out_valid_r <= 1'b1;
          cnt_r       <= '0;
          for (int c = 0; c < CHANNELS; c++) begin
            acc_r[c] <= '0;
          end
        end else begin
          acc_r <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid_r && s3_last_r) begin
      obuf_r <= acc_sum;
    end else if (out_valid_r && out_ch.ready) begin
      for (int c = 0; c < CHANNELS - 1; c++) begin
        obuf_r[c] <= obuf_r[c+1];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wsc_ram.sv
`default_nettype none

module wsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wsc_checker.sv
`default_nettype none

`include "weighted_sum_compositor_assert.svh"

module wsc_checker import wsc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  wsc_in_if.sink    in_ch,
  wsc_out_if.source out_ch
);

  logic take;

  assign take = out_ch.valid && out_ch.ready;

  `WSC_ASSERT_RST(a_reset_idle, !rst_n |=> !out_ch.valid && in_ch.ready, "not idle right after reset")
  `WSC_ASSERT(a_hold, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result dropped")
  `WSC_ASSERT(a_step, take && !out_ch.last_channel |=> out_ch.valid && (out_ch.out_channel == CHAN_W'($past(out_ch.out_channel) + CHAN_W'(1))), "channel sequence broken")
  `WSC_ASSERT(a_last, out_ch.valid |-> (out_ch.last_channel == (out_ch.out_channel == CHAN_W'(CHANNELS - 1))), "last channel flag wrong")
  `WSC_ASSERT(a_first, (!out_ch.valid || (take && out_ch.last_channel)) ##1 out_ch.valid |-> (out_ch.out_channel == '0), "burst does not start at channel zero")

endmodule

bind weighted_sum_compositor wsc_checker #(.CHANNELS(CHANNELS)) u_wsc_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_ch (in_ch),
  .out_ch(out_ch)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
  import wsc_pkg::*;

  localparam int CHANNELS   = CHANNELS_DEF;
  localparam int POINTS     = POINTS_DEF;
  localparam int RAND_ITEMS = 160;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [POINT_W-1:0] point;
    logic [CHAN_W-1:0]         chan;
    feat_t                     feat;
    logic [ALPHA_W-1:0]        alpha;
    logic                      last;
  } in_item_t;

  typedef struct {
    logic [CHAN_W-1:0] chan;
    acc_t              value;
    logic              last;
  } pix_result_t;

  typedef struct {
    in_item_t item;
    int       reps;
    bit       typed;
    acc_t     typed_val;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wsc_in_if  in_if ();
  wsc_out_if out_if ();

  weighted_sum_compositor #(
    .CHANNELS(CHANNELS),
    .POINTS  (POINTS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  feat_t       feat_mem [POINTS*CHANNELS];
  bit          feat_set [POINTS*CHANNELS];
  bit          pt_full  [POINTS];
  int          full_points [$];
  acc_t        chan_sum [CHANNELS];
  pix_result_t pending_results [$];
  stim_row_t   dir_rows [$];

  int fail_cnt  = 0;
  int rx_hold   = 0;
  bit rx_steady = 0;
  bit tx_steady = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic acc_t sat_sum(input acc_t a, input longint p);
    longint s;
    s = longint'(a) + p;
    if (s > longint'(ACC_MAX)) return ACC_MAX;
    if (s < longint'(ACC_MIN)) return ACC_MIN;
    return acc_t'(s);
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  function automatic feat_t pick_feature();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(FEAT_W-1){1'b1}}};
      1: return {1'b1, {(FEAT_W-1){1'b0}}};
      default: return feat_t'($urandom);
    endcase
  endfunction

  // Updates the feature table and the channel sums for one accepted item and
  // queues the pixel's results when the entry closes the pixel.
  task automatic apply_item(input in_item_t it, input bit typed, input acc_t typed_val);
    int pt;
    int idx;
    bit all_set;
    pix_result_t r;
    pt = it.point;
    if (it.cmd == CMD_LOAD) begin
      if (pt >= 0 && pt < POINTS && it.chan < CHANNELS) begin
        idx = pt * CHANNELS + it.chan;
        feat_mem[idx] = it.feat;
        feat_set[idx] = 1'b1;
        all_set = 1'b1;
        for (int c = 0; c < CHANNELS; c++) all_set &= feat_set[pt*CHANNELS + c];
        if (all_set && !pt_full[pt]) begin
          pt_full[pt] = 1'b1;
          full_points.push_back(pt);
        end
      end
    end else begin
      if (pt >= 0 && pt < POINTS) begin
        for (int c = 0; c < CHANNELS; c++) begin
          chan_sum[c] = sat_sum(chan_sum[c],
                                longint'(it.alpha) * longint'(feat_mem[pt*CHANNELS + c]));
        end
      end
      if (it.last) begin
        for (int c = 0; c < CHANNELS; c++) begin
          r.chan  = CHAN_W'(c);
          r.value = typed ? typed_val : chan_sum[c];
          r.last  = (c == CHANNELS - 1);
          pending_results.push_back(r);
          chan_sum[c] = '0;
        end
      end
    end
  endtask

  // Presents one item after a random gap; with drain set, the gap lasts until
  // every queued result has come out.
  task automatic send_item(input in_item_t it, input bit drain, input bit typed,
                           input acc_t typed_val);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (drain && gap == 0) gap = 1;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      while (drain && pending_results.size() != 0) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.command       <= it.cmd;
    in_if.point_index   <= it.point;
    in_if.channel       <= it.chan;
    in_if.feature_value <= it.feat;
    in_if.alpha         <= it.alpha;
    in_if.last_entry    <= it.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_item(it, typed, typed_val);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input int point, input int chan,
                         input int feat, input int alpha, input bit last, input int reps,
                         input bit typed, input acc_t typed_val);
    stim_row_t row;
    row.item.cmd   = cmd;
    row.item.point = POINT_W'(point);
    row.item.chan  = CHAN_W'(chan);
    row.item.feat  = feat_t'(feat);
    row.item.alpha = ALPHA_W'(alpha);
    row.item.last  = last;
    row.reps       = reps;
    row.typed      = typed;
    row.typed_val  = typed_val;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    pix_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result: channel %0d value %0d last %0d",
                               out_if.out_channel, out_if.value, out_if.last_channel));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.out_channel !== exp_r.chan || out_if.value !== exp_r.value ||
            out_if.last_channel !== exp_r.last) begin
          log_mismatch($sformatf(
            "channel exp %0d got %0d, value exp %0d got %0d, last exp %0d got %0d",
            exp_r.chan, out_if.out_channel, exp_r.value, out_if.value,
            exp_r.last, out_if.last_channel));
        end
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      rx_hold = rx_steady ? 0 : $urandom_range(0, 12);
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= (rx_hold == 0);
    end
  end

  initial begin
    in_item_t it;
    int counted;
    int sel;
    int pt;
    int len;
    int n;
    bit drain;

    in_if.valid         = 1'b0;
    in_if.command       = CMD_LOAD;
    in_if.point_index   = '0;
    in_if.channel       = '0;
    in_if.feature_value = '0;
    in_if.alpha         = '0;
    in_if.last_entry    = 1'b0;
    rst_n               = 1'b0;
    for (int c = 0; c < CHANNELS; c++) chan_sum[c] = '0;

    // Empty pixel straight after reset, then the table extremes.
    add_row(CMD_ENTRY, -1, 0, 0, 16'hFFFF, 1, 1, 1, '0);
    for (int c = 0; c < CHANNELS; c++) add_row(CMD_LOAD, 0, c, 32767, 0, 0, 1, 0, '0);
    for (int c = 0; c < CHANNELS; c++) add_row(CMD_LOAD, 1023, c, -32768, 0, 0, 1, 0, '0);
    // Loads with a negative index must not alias onto points 1023 or 0.
    add_row(CMD_LOAD, -1, 3, 16'h1234, 0, 0, 1, 0, '0);
    add_row(CMD_LOAD, -1024, 0, 7, 0, 1, 1, 0, '0);
    add_row(CMD_ENTRY, 1023, 0, 0, 1, 1, 1, 1, acc_t'(-32768));
    add_row(CMD_ENTRY, 0, 0, 0, 1, 1, 1, 1, acc_t'(32767));
    add_row(CMD_ENTRY, 0, 0, 0, 0, 1, 1, 1, '0);
    // A load marked last produces nothing.
    add_row(CMD_LOAD, 2, 0, 256, 0, 1, 1, 0, '0);
    add_row(CMD_LOAD, 2, 1, -256, 0, 0, 1, 0, '0);
    add_row(CMD_LOAD, 2, 2, 16'h5A5A, 0, 1, 1, 0, '0);
    add_row(CMD_LOAD, 2, 3, -1, 0, 0, 1, 0, '0);
    add_row(CMD_ENTRY, -1024, 0, 0, 16'hFFFF, 0, 1, 0, '0);
    add_row(CMD_ENTRY, 2, 0, 0, 16'h8000, 0, 1, 0, '0);
    add_row(CMD_ENTRY, 1023, 0, 0, 16'hFFFF, 0, 1, 0, '0);
    add_row(CMD_ENTRY, -1, 0, 0, 16'h1234, 1, 1, 0, '0);
    // Largest products of both signs in one pixel.
    add_row(CMD_ENTRY, 1023, 0, 0, 16'hFFFF, 0, 1, 0, '0);
    add_row(CMD_ENTRY, 0, 0, 0, 16'hFFFF, 1, 1, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        it      = dir_rows[i].item;
        it.last = dir_rows[i].item.last && (r == dir_rows[i].reps - 1);
        send_item(it, 1'b0, dir_rows[i].typed && (r == dir_rows[i].reps - 1),
                  dir_rows[i].typed_val);
      end
    end

    counted = 0;
    drain   = 1'b1;
    while (counted < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (full_points.size() < 4 || sel < 20) begin
        pt = $urandom_range(0, POINTS - 1);
        for (int c = 0; c < CHANNELS; c++) begin
          it.cmd   = CMD_LOAD;
          it.point = POINT_W'(pt);
          it.chan  = CHAN_W'(c);
          it.feat  = pick_feature();
          it.alpha = pick_alpha();
          it.last  = 1'($urandom_range(0, 1));
          send_item(it, drain, 1'b0, '0);
          drain = 1'b0;
          counted++;
        end
      end else if (sel < 30) begin
        it.cmd   = CMD_LOAD;
        it.point = POINT_W'($urandom_range(0, POINTS - 1));
        it.chan  = CHAN_W'($urandom);
        it.feat  = pick_feature();
        it.alpha = pick_alpha();
        it.last  = 1'($urandom_range(0, 1));
        send_item(it, drain, 1'b0, '0);
        drain = 1'b0;
        counted++;
      end else if (sel < 35) begin
        n        = $urandom_range(1, POINTS);
        it.cmd   = CMD_LOAD;
        it.point = POINT_W'(-n);
        it.chan  = CHAN_W'($urandom);
        it.feat  = pick_feature();
        it.alpha = pick_alpha();
        it.last  = 1'($urandom_range(0, 1));
        send_item(it, drain, 1'b0, '0);
        drain = 1'b0;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          it.cmd = CMD_ENTRY;
          if ($urandom_range(0, 4) == 0) begin
            n        = $urandom_range(1, POINTS);
            it.point = POINT_W'(-n);
          end else begin
            it.point = POINT_W'(full_points[$urandom_range(0, full_points.size() - 1)]);
          end
          it.chan  = CHAN_W'($urandom);
          it.feat  = feat_t'($urandom);
          it.alpha = pick_alpha();
          it.last  = (k == len - 1);
          send_item(it, drain, 1'b0, '0);
          drain = 1'b0;
          counted++;
        end
      end
      if ($urandom_range(0, 29) == 0) drain = 1'b1;
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
